### hw/rtl/tmb_pkg.sv
// Shared widths, command codes and unit operation type for the timer bank.
package tmb_pkg;

    localparam int MODE_W      = 3;
    localparam int SLOT_W      = 3;
    localparam int INTERVAL_W  = 31;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CREATE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_START  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STOP   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DELETE = 3'd4;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EVENT  = 1'b1;

    typedef enum logic {
        UNIT_ADD,
        UNIT_SUB
    } unit_op_t;

endpackage

### hw/rtl/multi_slot_timer_bank.sv
// Timer bank top level: command sequencer, slot flags and output register.
//
//  channel | direction | ports                                      | handshake
//  --------+-----------+--------------------------------------------+----------------
//  s_      | in        | s_mode s_slot s_interval s_periodic        | s_valid/s_ready
//  m_      | out       | m_kind m_slot_out m_ok m_last              | m_valid/m_ready
//
// Stop, delete and invalid commands go straight to the response step; start
// reads the interval RAM, then adds; a create with a nonzero interval walks the
// used flags for a free slot. A tick advances the counter, scans each slot (one
// time-unit pass for the compare, one more for a periodic rearm), then emits events.
// One word at a time in flight; s_ready is low while a word is worked on.
// Reset clears the counter and all slot flags; the interval and expiry RAMs are not cleared.
// A stalled m_ready holds the sequencer at its emit or response step.
module multi_slot_timer_bank
    import tmb_pkg::*;
#(
    parameter int NUM_SLOTS = 8,
    parameter int TIME_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [MODE_W-1:0]     s_mode,
    input  logic [SLOT_W-1:0]     s_slot,
    input  logic [INTERVAL_W-1:0] s_interval,
    input  logic                  s_periodic,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_kind,
    output logic [SLOT_W-1:0]     m_slot_out,
    output logic                  m_ok,
    output logic                  m_last
);

    localparam int IDX_W = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK,
        S_SCAN,
        S_CMP,
        S_REARM,
        S_EMIT,
        S_FIND,
        S_START_RD,
        S_START_ADD,
        S_RESP
    } state_t;

    state_t                  state_reg, state_next;
    logic [TIME_BITS-1:0]    now_reg, now_next;
    logic [NUM_SLOTS-1:0]    used_reg, used_next;
    logic [NUM_SLOTS-1:0]    armed_reg, armed_next;
    logic [NUM_SLOTS-1:0]    periodic_reg, periodic_next;
    logic [NUM_SLOTS-1:0]    fire_reg, fire_next;
    logic [CNT_W-1:0]        fire_cnt_reg, fire_cnt_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [IDX_W-1:0]        slot_reg, slot_next;
    logic [INTERVAL_W-1:0]   interval_reg, interval_next;
    logic                    new_periodic_reg, new_periodic_next;
    logic                    resp_ok_reg, resp_ok_next;
    logic [SLOT_W-1:0]       resp_slot_reg, resp_slot_next;

    logic                    m_valid_reg, m_valid_next;
    logic                    m_kind_reg, m_kind_next;
    logic [SLOT_W-1:0]       m_slot_out_reg, m_slot_out_next;
    logic                    m_ok_reg, m_ok_next;
    logic                    m_last_reg, m_last_next;

    unit_op_t                unit_op;
    logic [TIME_BITS-1:0]    unit_b;
    logic [TIME_BITS-1:0]    unit_result;

    logic                    iv_wr_en;
    logic                    ex_wr_en;
    logic [IDX_W-1:0]        ex_wr_addr;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic [INTERVAL_W-1:0]   iv_rd_data;
    logic [TIME_BITS-1:0]    ex_rd_data;

    logic                    out_free;
    logic                    s_accept;
    logic [IDX_W-1:0]        in_idx;
    logic                    in_slot_ok;
    logic                    idx_last;
    logic [NUM_SLOTS-1:0]    fire_rest;

    tmb_ram #(
        .WIDTH (INTERVAL_W),
        .DEPTH (NUM_SLOTS)
    ) u_interval_ram (
        .aclk    (aclk),
        .wr_en   (iv_wr_en),
        .wr_addr (idx_reg),
        .wr_data (interval_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (iv_rd_data)
    );

    tmb_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (NUM_SLOTS)
    ) u_expiry_ram (
        .aclk    (aclk),
        .wr_en   (ex_wr_en),
        .wr_addr (ex_wr_addr),
        .wr_data (unit_result),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ex_rd_data)
    );

    tmb_time_unit #(
        .TIME_BITS (TIME_BITS)
    ) u_time_unit (
        .op     (unit_op),
        .a      (now_reg),
        .b      (unit_b),
        .result (unit_result)
    );

    assign s_ready    = (state_reg == S_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign in_idx     = IDX_W'(s_slot);
    assign in_slot_ok = (int'(s_slot) < NUM_SLOTS) && used_reg[in_idx];
    assign idx_last   = (idx_reg == LAST_IDX);

    assign rd_en      = (state_reg == S_SCAN) || (state_reg == S_START_RD);
    assign rd_addr    = (state_reg == S_START_RD) ? slot_reg : idx_reg;
    assign ex_wr_addr = (state_reg == S_START_ADD) ? slot_reg : idx_reg;
    assign ex_wr_en   = (state_reg == S_START_ADD) || (state_reg == S_REARM);
    assign iv_wr_en   = (state_reg == S_FIND) && !used_reg[idx_reg];

    always_comb begin
        fire_rest          = fire_reg;
        fire_rest[idx_reg] = 1'b0;
    end

    always_comb begin
        case (state_reg)
            S_TICK: begin
                unit_op = UNIT_ADD;
                unit_b  = TIME_BITS'(1);
            end
            S_CMP: begin
                unit_op = UNIT_SUB;
                unit_b  = ex_rd_data;
            end
            default: begin
                unit_op = UNIT_ADD;
                unit_b  = TIME_BITS'(iv_rd_data);
            end
        endcase
    end

    always_comb begin
        state_next        = state_reg;
        now_next          = now_reg;
        used_next         = used_reg;
        armed_next        = armed_reg;
        periodic_next     = periodic_reg;
        fire_next         = fire_reg;
        fire_cnt_next     = fire_cnt_reg;
        idx_next          = idx_reg;
        slot_next         = slot_reg;
        interval_next     = interval_reg;
        new_periodic_next = new_periodic_reg;
        resp_ok_next      = resp_ok_reg;
        resp_slot_next    = resp_slot_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_kind_next       = m_kind_reg;
        m_slot_out_next   = m_slot_out_reg;
        m_ok_next         = m_ok_reg;
        m_last_next       = m_last_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    slot_next         = in_idx;
                    interval_next     = s_interval;
                    new_periodic_next = s_periodic;
                    idx_next          = '0;
                    resp_ok_next      = 1'b0;
                    resp_slot_next    = s_slot;
                    state_next        = S_RESP;
                    case (s_mode)
                        MODE_TICK: begin
                            state_next = S_TICK;
                        end
                        MODE_CREATE: begin
                            resp_slot_next = '0;
                            if (s_interval != '0) begin
                                state_next = S_FIND;
                            end
                        end
                        MODE_START: begin
                            if (in_slot_ok) begin
                                state_next = S_START_RD;
                            end
                        end
                        MODE_STOP: begin
                            if (in_slot_ok) begin
                                armed_next[in_idx] = 1'b0;
                                resp_ok_next       = 1'b1;
                            end
                        end
                        MODE_DELETE: begin
                            if (in_slot_ok) begin
                                armed_next[in_idx]    = 1'b0;
                                used_next[in_idx]     = 1'b0;
                                periodic_next[in_idx] = 1'b0;
                                resp_ok_next          = 1'b1;
                            end
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_FIND: begin
                if (!used_reg[idx_reg]) begin
                    used_next[idx_reg]     = 1'b1;
                    armed_next[idx_reg]    = 1'b0;
                    periodic_next[idx_reg] = new_periodic_reg;
                    resp_ok_next           = 1'b1;
                    resp_slot_next         = SLOT_W'(idx_reg);
                    state_next             = S_RESP;
                end else if (idx_last) begin
                    state_next = S_RESP;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_START_RD: begin
                state_next = S_START_ADD;
            end
            S_START_ADD: begin
                armed_next[slot_reg] = 1'b1;
                resp_ok_next         = 1'b1;
                resp_slot_next       = SLOT_W'(slot_reg);
                state_next           = S_RESP;
            end
            S_TICK: begin
                now_next      = unit_result;
                fire_next     = '0;
                fire_cnt_next = '0;
                state_next    = S_SCAN;
            end
            S_SCAN: begin
                if (fire_cnt_reg == CNT_W'(MAX_RESULTS)) begin
                    idx_next   = '0;
                    state_next = S_EMIT;
                end else if (used_reg[idx_reg] && armed_reg[idx_reg]) begin
                    state_next = S_CMP;
                end else if (idx_last) begin
                    idx_next   = '0;
                    state_next = S_EMIT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_CMP: begin
                state_next = S_SCAN;
                if (!unit_result[TIME_BITS-1]) begin
                    fire_next[idx_reg] = 1'b1;
                    fire_cnt_next      = fire_cnt_reg + 1'b1;
                    if (periodic_reg[idx_reg]) begin
                        state_next = S_REARM;
                    end else begin
                        armed_next[idx_reg] = 1'b0;
                    end
                end
                if (state_next == S_SCAN) begin
                    if (idx_last) begin
                        idx_next   = '0;
                        state_next = S_EMIT;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_REARM: begin
                if (idx_last) begin
                    idx_next   = '0;
                    state_next = S_EMIT;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_EMIT: begin
                if (fire_reg == '0) begin
                    state_next = S_IDLE;
                end else if (fire_reg[idx_reg]) begin
                    if (out_free) begin
                        m_valid_next    = 1'b1;
                        m_kind_next     = KIND_EVENT;
                        m_slot_out_next = SLOT_W'(idx_reg);
                        m_ok_next       = 1'b1;
                        m_last_next     = (fire_rest == '0);
                        fire_next       = fire_rest;
                        idx_next        = idx_reg + 1'b1;
                        if (fire_rest == '0) begin
                            state_next = S_IDLE;
                        end
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_kind_next     = KIND_STATUS;
                    m_slot_out_next = resp_slot_reg;
                    m_ok_next       = resp_ok_reg;
                    m_last_next     = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            now_reg      <= '0;
            used_reg     <= '0;
            armed_reg    <= '0;
            periodic_reg <= '0;
            fire_reg     <= '0;
            fire_cnt_reg <= '0;
            idx_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            now_reg      <= now_next;
            used_reg     <= used_next;
            armed_reg    <= armed_next;
            periodic_reg <= periodic_next;
            fire_reg     <= fire_next;
            fire_cnt_reg <= fire_cnt_next;
            idx_reg      <= idx_next;
            m_valid_reg  <= m_valid_next;
        end
        slot_reg         <= slot_next;
        interval_reg     <= interval_next;
        new_periodic_reg <= new_periodic_next;
        resp_ok_reg      <= resp_ok_next;
        resp_slot_reg    <= resp_slot_next;
        m_kind_reg       <= m_kind_next;
        m_slot_out_reg   <= m_slot_out_next;
        m_ok_reg         <= m_ok_next;
        m_last_reg       <= m_last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_kind     = m_kind_reg;
    assign m_slot_out = m_slot_out_reg;
    assign m_ok       = m_ok_reg;
    assign m_last     = m_last_reg;

endmodule

### hw/rtl/tmb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tmb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/tmb_time_unit.sv
// Shared time adder/subtractor: counter advance, expiry compare, start and rearm sums.
module tmb_time_unit
    import tmb_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  unit_op_t             op,
    input  logic [TIME_BITS-1:0] a,
    input  logic [TIME_BITS-1:0] b,
    output logic [TIME_BITS-1:0] result
);

    always_comb begin
        case (op)
            UNIT_ADD: result = a + b;
            UNIT_SUB: result = a - b;
            default:  result = a + b;
        endcase
    end

endmodule

### test/tmb_expiry_checker.sv
// Timer bank checker: predicts status words and expiry events, compares the result channel.
`timescale 1ns / 100ps

module tmb_expiry_checker
    import tmb_pkg::*;
#(
    parameter int NUM_SLOTS = 8,
    parameter int TIME_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [MODE_W-1:0]     s_mode,
    input  logic [SLOT_W-1:0]     s_slot,
    input  logic [INTERVAL_W-1:0] s_interval,
    input  logic                  s_periodic,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_kind,
    input  logic [SLOT_W-1:0]     m_slot_out,
    input  logic                  m_ok,
    input  logic                  m_last,
    output int                    mismatches,
    output int                    outstanding
);

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        logic              ok;
        logic              last;
    } bank_word_t;

    bank_word_t            due_words[$];
    bank_word_t            got;
    bank_word_t            want;
    logic [TIME_BITS-1:0]  now_ms;
    logic [NUM_SLOTS-1:0]  in_use;
    logic [NUM_SLOTS-1:0]  running;
    logic [NUM_SLOTS-1:0]  repeats;
    logic [INTERVAL_W-1:0] period_len [NUM_SLOTS];
    logic [TIME_BITS-1:0]  due_at [NUM_SLOTS];
    int                    err_count;

    task automatic apply_command(input logic [MODE_W-1:0] mode, input logic [SLOT_W-1:0] slot,
                                 input logic [INTERVAL_W-1:0] ivl, input logic per);
        logic [NUM_SLOTS-1:0] reached;
        logic [TIME_BITS-1:0] lag;
        logic                 ok;
        logic [SLOT_W-1:0]    which;
        bank_word_t           w;
        ok = 1'b0;
        which = slot;
        reached = '0;
        case (mode)
            MODE_TICK: begin
                now_ms = now_ms + 1'b1;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    lag = now_ms - due_at[i];
                    reached[i] = in_use[i] && running[i] && !lag[TIME_BITS-1];
                end
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (reached[i]) begin
                        w.kind = KIND_EVENT;
                        w.slot = SLOT_W'(i);
                        w.ok   = 1'b1;
                        w.last = ((reached >> (i + 1)) == '0);
                        due_words.push_back(w);
                        if (repeats[i]) begin
                            due_at[i] = now_ms + period_len[i];
                        end else begin
                            running[i] = 1'b0;
                        end
                    end
                end
                return;
            end
            MODE_CREATE: begin
                which = '0;
                if (ivl != '0) begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (!ok && !in_use[i]) begin
                            in_use[i]     = 1'b1;
                            running[i]    = 1'b0;
                            repeats[i]    = per;
                            period_len[i] = ivl;
                            due_at[i]     = '0;
                            which         = SLOT_W'(i);
                            ok            = 1'b1;
                        end
                    end
                end
            end
            MODE_START: begin
                if (in_use[slot]) begin
                    ok = 1'b1;
                    running[slot] = 1'b1;
                    due_at[slot]  = now_ms + period_len[slot];
                end
            end
            MODE_STOP: begin
                if (in_use[slot]) begin
                    ok = 1'b1;
                    running[slot] = 1'b0;
                end
            end
            MODE_DELETE: begin
                if (in_use[slot]) begin
                    ok = 1'b1;
                    running[slot] = 1'b0;
                    in_use[slot]  = 1'b0;
                    repeats[slot] = 1'b0;
                end
            end
            default: begin
            end
        endcase
        w.kind = KIND_STATUS;
        w.slot = which;
        w.ok   = ok;
        w.last = 1'b1;
        due_words.push_back(w);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            due_words.delete();
            now_ms    = '0;
            in_use    = '0;
            running   = '0;
            repeats   = '0;
            err_count = 0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                period_len[i] = '0;
                due_at[i]     = '0;
            end
        end else begin
            if (m_valid && m_ready) begin
                got.kind = m_kind;
                got.slot = m_slot_out;
                got.ok   = m_ok;
                got.last = m_last;
                if (due_words.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected word: expected none, got kind=%0d slot=%0d ok=%0d last=%0d",
                             $time, got.kind, got.slot, got.ok, got.last);
                end else begin
                    want = due_words.pop_front();
                    if (got.kind !== want.kind || got.slot !== want.slot ||
                        got.ok !== want.ok || got.last !== want.last) begin
                        err_count++;
                        $display("%0t: mismatch: expected kind=%0d slot=%0d ok=%0d last=%0d, got kind=%0d slot=%0d ok=%0d last=%0d",
                                 $time, want.kind, want.slot, want.ok, want.last,
                                 got.kind, got.slot, got.ok, got.last);
                    end
                end
            end
            if (s_valid && s_ready) begin
                apply_command(s_mode, s_slot, s_interval, s_periodic);
            end
        end
        mismatches  <= err_count;
        outstanding <= due_words.size();
    end

endmodule

### test/tb_multi_slot_timer_bank.sv
// Testbench top for the timer bank: command stimulus, result back-pressure and verdict.
`timescale 1ns / 100ps

module tb_multi_slot_timer_bank;
    import tmb_pkg::*;

    localparam int NUM_SLOTS    = 8;
    localparam int TIME_BITS    = 32;
    localparam int RANDOM_WORDS = 405;
    localparam int CALM_WORDS   = 60;
    localparam int DRAIN_CYCLES = 64;
    localparam int QUIET_LIMIT  = 2000;

    localparam logic [MODE_W-1:0] MODE_UNKNOWN_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNKNOWN_HI = 3'd7;

    logic                  aclk       = 1'b0;
    logic                  aresetn    = 1'b0;
    logic                  s_valid    = 1'b0;
    logic                  s_ready;
    logic [MODE_W-1:0]     s_mode     = MODE_TICK;
    logic [SLOT_W-1:0]     s_slot     = '0;
    logic [INTERVAL_W-1:0] s_interval = '0;
    logic                  s_periodic = 1'b0;
    logic                  m_valid;
    logic                  m_ready    = 1'b1;
    logic                  m_kind;
    logic [SLOT_W-1:0]     m_slot_out;
    logic                  m_ok;
    logic                  m_last;

    int mismatches;
    int outstanding;
    int gap_pct    = 0;
    int stall_pct  = 0;
    int ready_hold = 0;
    int quiet      = 0;

    multi_slot_timer_bank #(
        .NUM_SLOTS(NUM_SLOTS),
        .TIME_BITS(TIME_BITS)
    ) dut (.*);

    tmb_expiry_checker #(
        .NUM_SLOTS(NUM_SLOTS),
        .TIME_BITS(TIME_BITS)
    ) checker_i (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn || stall_pct == 0) begin
            m_ready    <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            m_ready    <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            m_ready    <= 1'b0;
            ready_hold <= $urandom_range(0, 3);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("tb_multi_slot_timer_bank: errors");
            $finish;
        end
    end

    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [SLOT_W-1:0] slot,
                             input logic [INTERVAL_W-1:0] ivl, input logic per);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_mode     <= mode;
        s_slot     <= slot;
        s_interval <= ivl;
        s_periodic <= per;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    initial begin
        logic [MODE_W-1:0]     mode;
        logic [INTERVAL_W-1:0] ivl;
        int                    pick;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reject zero interval, idle tick, commands on free slots, unknown modes
        send_word(MODE_CREATE, 3'd0, '0, 1'b1);
        send_word(MODE_TICK, 3'd0, '0, 1'b0);
        send_word(MODE_START, 3'd0, 31'h7FFF_FFFF, 1'b1);
        send_word(MODE_STOP, 3'd3, '0, 1'b0);
        send_word(MODE_DELETE, 3'd7, '0, 1'b0);
        send_word(MODE_UNKNOWN_LO, 3'd2, 31'h5555_5555, 1'b0);
        send_word(MODE_UNKNOWN_HI, 3'd7, 31'h2AAA_AAAA, 1'b1);
        // periodic, far-off one-shot, short one-shot; stop while disarmed
        send_word(MODE_CREATE, 3'd5, 31'd1, 1'b1);
        send_word(MODE_CREATE, 3'd0, 31'h7FFF_FFFF, 1'b0);
        send_word(MODE_CREATE, 3'd7, 31'd2, 1'b0);
        send_word(MODE_STOP, 3'd2, '0, 1'b0);
        send_word(MODE_START, 3'd0, '0, 1'b0);
        send_word(MODE_START, 3'd1, '0, 1'b0);
        send_word(MODE_START, 3'd2, '0, 1'b0);
        send_word(MODE_TICK, 3'd0, '0, 1'b0);
        send_word(MODE_TICK, 3'd0, '0, 1'b0);
        send_word(MODE_TICK, 3'd0, '0, 1'b0);
        // fill the bank, then overflow it
        for (int i = 0; i < NUM_SLOTS - 3; i++) begin
            send_word(MODE_CREATE, 3'd0, 31'd3, 1'b1);
        end
        send_word(MODE_CREATE, 3'd0, 31'd4, 1'b0);
        send_word(MODE_DELETE, 3'd1, '0, 1'b0);
        send_word(MODE_DELETE, 3'd0, '0, 1'b0);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 20;
                    default: gap_pct = 50;
                endcase
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    default: stall_pct = 50;
                endcase
            end
            if (n >= RANDOM_WORDS - CALM_WORDS) begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            if (n == RANDOM_WORDS / 2) begin
                s_valid <= 1'b0;
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                mode = MODE_TICK;
            end else if (pick < 58) begin
                mode = MODE_CREATE;
            end else if (pick < 78) begin
                mode = MODE_START;
            end else if (pick < 86) begin
                mode = MODE_STOP;
            end else if (pick < 96) begin
                mode = MODE_DELETE;
            end else begin
                mode = MODE_W'($urandom_range(MODE_UNKNOWN_LO, MODE_UNKNOWN_HI));
            end
            ivl = INTERVAL_W'($urandom);
            if (mode == MODE_CREATE) begin
                pick = $urandom_range(0, 19);
                if (pick < 14) begin
                    ivl = INTERVAL_W'($urandom_range(1, 6));
                end else if (pick < 18) begin
                    ivl = INTERVAL_W'($urandom_range(7, 40));
                end else if (pick == 18) begin
                    ivl = '0;
                end
            end
            send_word(mode, SLOT_W'($urandom_range(0, NUM_SLOTS - 1)), ivl,
                      1'($urandom_range(0, 1)));
        end
        s_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_multi_slot_timer_bank: clean");
        end else begin
            $display("tb_multi_slot_timer_bank: errors");
        end
        $finish;
    end

endmodule
